@@ hw/rtl/wlm_pkg.sv @@
// Shared types and constants for the wildcard line matcher.
// No dependencies; imported by every module of the block.
package wlm_pkg;

	localparam int PATTERN_LEN = 16;
	localparam int POS_W       = $clog2(PATTERN_LEN + 1);
	localparam int MAX_LINE    = 1023;
	localparam int LINE_CNT_W  = $clog2(MAX_LINE + 2);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [7:0] STAR_CHAR = 8'h2A;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

	typedef logic [PATTERN_LEN-1:0][7:0] char_vec_t;

	typedef struct packed {
		logic             found;
		logic             hit;
		logic [POS_W-1:0] next_start;
	} seg_res_t;

endpackage

@@ hw/rtl/wildcard_line_matcher.sv @@
// Top level of the wildcard line matcher: input stage, per-line state and
// result register. Depends on wlm_pkg, wlm_cfg_regs and wlm_seg_match.
//
// One character is taken per cycle. A line's last character passes the input
// stage and then the result register before its verdict is presented. The
// whole segment search and window compare is a single pass of logic between
// the input stage and the line state, so the sustained rate is one character
// per cycle. The output register lets the next line stream in while a verdict
// waits; only an end-of-line character stalls, and only while an earlier
// verdict is still unread. Configuration writes are taken at once and must
// fall between lines.
module wildcard_line_matcher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     line_char,
	input  logic                           end_of_line,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           line_matches,
	output logic                           line_too_long,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wlm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wlm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wlm_pkg::*;

	char_vec_t             pattern;
	logic [POS_W-1:0]      pattern_len;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  eol_s1;
	logic                  adv_s1;

	char_vec_t             window_q;
	char_vec_t             window_next;
	logic [POS_W-1:0]      seg_start_q;
	logic [POS_W-1:0]      since_seg_q;
	logic [POS_W-1:0]      since_inc;
	logic                  found_q;
	logic                  found_next;
	logic [LINE_CNT_W-1:0] line_cnt_q;
	logic [LINE_CNT_W-1:0] line_cnt_next;
	logic                  overlong_q;
	logic                  overlong_next;
	seg_res_t              seg_res;

	logic                  out_valid_q;
	logic                  matches_q;
	logic                  too_long_q;

	assign cfg_ready = 1'b1;

	wlm_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (cfg_valid),
		.wr_index    (cfg_index),
		.wr_data     (cfg_data),
		.pattern     (pattern),
		.pattern_len (pattern_len)
	);

	assign adv_s1   = valid_s1 && (!eol_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= line_char;
			eol_s1  <= end_of_line;
		end
	end

	always_comb begin
		window_next                  = window_q >> 8;
		window_next[PATTERN_LEN - 1] = char_s1;
		line_cnt_next = (line_cnt_q <= LINE_CNT_W'(MAX_LINE)) ? line_cnt_q + 1'b1 : line_cnt_q;
		overlong_next = overlong_q || (line_cnt_next > LINE_CNT_W'(MAX_LINE));
		since_inc     = (since_seg_q < POS_W'(PATTERN_LEN)) ? since_seg_q + 1'b1 : since_seg_q;
		found_next    = found_q || seg_res.found;
	end

	wlm_seg_match u_seg (
		.pattern     (pattern),
		.pattern_len (pattern_len),
		.seg_start   (seg_start_q),
		.since_seg   (since_inc),
		.window      (window_next),
		.res         (seg_res)
	);

	always_ff @(posedge clk) begin
		if (adv_s1)
			window_q <= window_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q <= '0;
			since_seg_q <= '0;
			found_q     <= 1'b0;
			line_cnt_q  <= '0;
			overlong_q  <= 1'b0;
		end else if (adv_s1) begin
			if (eol_s1) begin
				seg_start_q <= '0;
				since_seg_q <= '0;
				found_q     <= 1'b0;
				line_cnt_q  <= '0;
				overlong_q  <= 1'b0;
			end else begin
				line_cnt_q <= line_cnt_next;
				overlong_q <= overlong_next;
				found_q    <= found_next;
				if (!found_q && seg_res.hit) begin
					seg_start_q <= seg_res.next_start;
					since_seg_q <= '0;
				end else begin
					since_seg_q <= since_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && eol_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eol_s1) begin
			matches_q  <= found_next && !overlong_next;
			too_long_q <= overlong_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_matches  = matches_q;
	assign line_too_long = too_long_q;

	a_no_match_when_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(line_matches && line_too_long))
		else $error("overlong line reported as matching");

	a_line_state_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eol_s1) |=> (line_cnt_q == '0 && seg_start_q == '0 && !found_q))
		else $error("line state not cleared after end of line");

	a_seg_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		seg_start_q <= POS_W'(PATTERN_LEN))
		else $error("segment start beyond pattern store");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

endmodule

@@ hw/rtl/wlm_cfg_regs.sv @@
// Pattern configuration registers of the wildcard line matcher.
// Depends on wlm_pkg; the pattern length is saturated to the pattern store.
module wlm_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [wlm_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [wlm_pkg::CFG_DATA_W-1:0] wr_data,
	output wlm_pkg::char_vec_t            pattern,
	output logic [wlm_pkg::POS_W-1:0]     pattern_len
);
	import wlm_pkg::*;

	char_vec_t  pat_q;
	logic [4:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PAT_LOW:  pat_q[7:0]  <= wr_data;
				REG_PAT_HIGH: pat_q[15:8] <= wr_data;
				REG_PAT_LEN:  len_q       <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	assign pattern     = pat_q;
	assign pattern_len = (len_q > 5'(PATTERN_LEN)) ? POS_W'(PATTERN_LEN) : POS_W'(len_q);

endmodule

@@ hw/rtl/wlm_seg_match.sv @@
// Segment finder: locates the sought pattern segment and compares it
// against the character window in one pass. Depends on wlm_pkg.
module wlm_seg_match (
	input  wlm_pkg::char_vec_t        pattern,
	input  logic [wlm_pkg::POS_W-1:0] pattern_len,
	input  logic [wlm_pkg::POS_W-1:0] seg_start,
	input  logic [wlm_pkg::POS_W-1:0] since_seg,
	input  wlm_pkg::char_vec_t        window,
	output wlm_pkg::seg_res_t         res
);
	import wlm_pkg::*;

	logic [PATTERN_LEN-1:0] nonstar;
	logic [PATTERN_LEN-1:0] in_len;
	logic [PATTERN_LEN-1:0] in_seg;
	logic [PATTERN_LEN-1:0] char_ok;
	logic [PATTERN_LEN-1:0] rest;
	logic [POS_W-1:0]       s_pos;
	logic [POS_W-1:0]       e_pos;
	logic [POS_W-1:0]       seg_len;
	logic [POS_W-1:0]       shift;
	logic [POS_W-1:0]       w_idx [PATTERN_LEN];
	logic                   none_left;
	logic                   rest_empty;
	logic                   hit;

	always_comb begin
		s_pos = pattern_len;
		for (int j = PATTERN_LEN - 1; j >= 0; j--) begin
			nonstar[j] = pattern[j] != STAR_CHAR;
			in_len[j]  = POS_W'(j) < pattern_len;
			if (nonstar[j] && in_len[j] && POS_W'(j) >= seg_start)
				s_pos = POS_W'(j);
		end
		none_left = s_pos >= pattern_len;

		e_pos = pattern_len;
		for (int j = PATTERN_LEN - 1; j >= 0; j--) begin
			if (!nonstar[j] && in_len[j] && POS_W'(j) >= s_pos)
				e_pos = POS_W'(j);
		end
		seg_len = e_pos - s_pos;
		shift   = POS_W'(PATTERN_LEN) - e_pos;

		for (int j = 0; j < PATTERN_LEN; j++) begin
			in_seg[j]  = POS_W'(j) >= s_pos && POS_W'(j) < e_pos;
			w_idx[j]   = POS_W'(j) + shift;
			char_ok[j] = !in_seg[j] || (window[w_idx[j][POS_W-2:0]] == pattern[j]);
			rest[j]    = nonstar[j] && in_len[j] && POS_W'(j) >= e_pos;
		end
		rest_empty = ~|rest;
		hit        = !none_left && (seg_len <= since_seg) && (&char_ok);

		res.hit        = hit;
		res.next_start = e_pos;
		res.found      = none_left || (hit && rest_empty);
	end

endmodule

@@ dv/tb_wildcard_line_matcher.sv @@
// Self-checking bench for wildcard_line_matcher: streams lines of text, predicts
// each line verdict and compares it with the block's. Depends on wlm_pkg and the RTL.
module tb_wildcard_line_matcher;
	import wlm_pkg::*;

	localparam int         LIMIT   = 400000;
	localparam int         SETTLE  = 4;
	localparam logic [7:0] NEWLINE = 8'h0A;
	localparam logic [7:0] CH_A    = 8'h61;

	typedef struct packed {
		logic match_ok;
		logic too_long;
	} verdict_t;

	class line_scoreboard;
		logic [63:0] chars_lo, chars_hi;
		logic [4:0]  len_reg;
		logic [7:0]  window [PATTERN_LEN];
		int unsigned seg_begin, since_hit, line_count;
		bit          done, overlong;
		verdict_t    verdict_q [$];
		int          errors, checked, lines, matched, long_lines;

		function new();
			chars_lo = '0;
			chars_hi = '0;
			len_reg  = '0;
			foreach (window[k]) window[k] = '0;
			clear_line();
		endfunction

		function void clear_line();
			seg_begin  = 0;
			since_hit  = 0;
			line_count = 0;
			done       = 1'b0;
			overlong   = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PAT_LOW:  chars_lo = data;
				REG_PAT_HIGH: chars_hi = data;
				REG_PAT_LEN:  len_reg  = data[4:0];
				default: ;
			endcase
		endfunction

		function int unsigned used_len();
			int unsigned n;
			n = len_reg;
			if (n > 16) n = 16;
			if (n > PATTERN_LEN) n = PATTERN_LEN;
			return n;
		endfunction

		function logic [7:0] pat_byte(int unsigned i);
			if (i < 8) return chars_lo[8*i +: 8];
			if (i < 16) return chars_hi[8*(i-8) +: 8];
			return 8'h00;
		endfunction

		function int unsigned past_stars(int unsigned s, int unsigned n);
			while (s < n && pat_byte(s) == STAR_CHAR) s++;
			return s;
		endfunction

		function void note_char(logic [7:0] c, logic eol);
			int unsigned n, s, e, seg;
			bit          hit;
			verdict_t    v;
			n = used_len();
			for (int k = 0; k < PATTERN_LEN - 1; k++) window[k] = window[k+1];
			window[PATTERN_LEN-1] = c;
			if (line_count <= MAX_LINE) line_count++;
			if (line_count > MAX_LINE) overlong = 1'b1;
			if (since_hit < PATTERN_LEN) since_hit++;
			if (!done) begin
				s = past_stars(seg_begin, n);
				if (s >= n) begin
					done = 1'b1;
				end else begin
					e = s;
					while (e < n && pat_byte(e) != STAR_CHAR) e++;
					seg = e - s;
					hit = (seg <= since_hit);
					for (int unsigned k = 0; hit && k < seg; k++)
						if (window[PATTERN_LEN - seg + k] != pat_byte(s + k)) hit = 1'b0;
					if (hit) begin
						seg_begin = e;
						since_hit = 0;
						if (past_stars(e, n) >= n) done = 1'b1;
					end
				end
			end
			if (eol) begin
				v.match_ok = done && !overlong;
				v.too_long = overlong;
				verdict_q.push_back(v);
				lines++;
				if (v.match_ok) matched++;
				if (v.too_long) long_lines++;
				clear_line();
			end
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		task report_mismatch(string what);
			$display("mismatch on verdict %0d: %s", checked, what);
			errors++;
		endtask

		task check_verdict(logic m, logic tl);
			verdict_t v;
			checked++;
			if (verdict_q.size() == 0) begin
				report_mismatch("verdict with no line outstanding");
			end else begin
				v = verdict_q.pop_front();
				if (m !== v.match_ok)
					report_mismatch($sformatf("line_matches %b, want %b", m, v.match_ok));
				if (tl !== v.too_long)
					report_mismatch($sformatf("line_too_long %b, want %b", tl, v.too_long));
			end
		endtask
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic [7:0]            line_char     = '0;
	logic                  end_of_line   = 1'b0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic                  line_matches;
	logic                  line_too_long;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	line_scoreboard sb;
	int             send_idle, recv_idle, cycles, settings_used, chars_sent;
	logic [7:0]     pat_bytes [16];
	int             pat_used;
	logic [7:0]     line_buf [$];

	wildcard_line_matcher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.line_char    (line_char),
		.end_of_line  (end_of_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.line_matches (line_matches),
		.line_too_long(line_too_long),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_verdict(line_matches, line_too_long);
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_char(logic [7:0] c, logic eol);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		line_char   <= c;
		end_of_line <= eol;
		do @(posedge clk); while (!in_ready);
		sb.note_char(c, eol);
		chars_sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// hold the stream at a line boundary, then load pat_bytes with the given length code
	task automatic apply_pattern(int len_code);
		logic [63:0] lo, hi;
		drain();
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pat_bytes[i];
			hi[8*i +: 8] = pat_bytes[i+8];
		end
		write_reg(REG_PAT_LOW, lo);
		write_reg(REG_PAT_HIGH, hi);
		write_reg(REG_PAT_LEN, CFG_DATA_W'(len_code));
		cfg_valid <= 1'b0;
		pat_used = (len_code > 16) ? 16 : len_code;
		settings_used++;
	endtask

	function automatic logic [7:0] filler();
		int r;
		r = $urandom_range(99);
		if (r < 85) return CH_A + 8'($urandom_range(2));
		if (r < 90) return STAR_CHAR;
		return 8'($urandom_range(255));
	endfunction

	task automatic new_pattern();
		int r, len_code;
		foreach (pat_bytes[i]) begin
			r = $urandom_range(99);
			if (r < 25) pat_bytes[i] = STAR_CHAR;
			else if (r < 88) pat_bytes[i] = CH_A + 8'($urandom_range(2));
			else pat_bytes[i] = 8'($urandom_range(255));
		end
		r = $urandom_range(99);
		if (r < 10) len_code = $urandom_range(31, 17);
		else if (r < 15) len_code = 0;
		else len_code = $urandom_range(16, 1);
		apply_pattern(len_code);
	endtask

	// mode 0: segments in order with filler, 1: same with one char damaged, 2: noise
	task automatic build_line(int mode, int min_len);
		int n, pos;
		line_buf.delete();
		if (mode == 2) begin
			n = $urandom_range(24, 1);
			repeat (n) line_buf.push_back(filler());
		end else begin
			repeat ($urandom_range(2)) line_buf.push_back(filler());
			for (int i = 0; i < pat_used; i++) begin
				if (pat_bytes[i] == STAR_CHAR) repeat ($urandom_range(3)) line_buf.push_back(filler());
				else line_buf.push_back(pat_bytes[i]);
			end
			repeat ($urandom_range(2)) line_buf.push_back(filler());
			if (mode == 1 && line_buf.size() != 0) begin
				pos = $urandom_range(line_buf.size() - 1);
				if ($urandom_range(1)) line_buf.delete(pos);
				else line_buf[pos] = filler();
			end
			line_buf.push_back(($urandom_range(3) == 0) ? filler() : NEWLINE);
		end
		while (line_buf.size() < min_len) line_buf.push_front(filler());
	endtask

	task automatic run_phase(int s_idle, int r_idle, int long_len);
		int start, since_cfg, r;
		send_idle = s_idle;
		recv_idle = r_idle;
		start     = chars_sent;
		new_pattern();
		build_line(0, long_len);
		send_line();
		since_cfg = 1;
		while (chars_sent - start - long_len < 135) begin
			if (since_cfg >= 5) begin
				new_pattern();
				since_cfg = 0;
			end
			r = $urandom_range(99);
			build_line((r < 65) ? 0 : (r < 85) ? 1 : 2, 1);
			send_line();
			since_cfg++;
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 16;
		recv_idle = 82;

		// empty pattern after reset, extreme byte values in the line
		line_buf = '{8'h00, 8'hFF};
		send_line();

		// pattern made of stars only
		foreach (pat_bytes[i]) pat_bytes[i] = STAR_CHAR;
		apply_pattern(16);
		line_buf = '{8'h78, 8'h79};
		send_line();

		// zero and all-ones bytes are ordinary pattern characters
		foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
		pat_bytes[1] = 8'hFF;
		pat_bytes[2] = STAR_CHAR;
		pat_bytes[3] = 8'h41;
		apply_pattern(4);
		line_buf = '{8'h00, 8'hFF, 8'h41, NEWLINE};
		send_line();
		line_buf = '{8'h00, 8'h41, 8'hFF, NEWLINE};
		send_line();

		// length code beyond sixteen saturates; full window without stars
		foreach (pat_bytes[i]) pat_bytes[i] = CH_A + 8'(i);
		apply_pattern(31);
		line_buf.delete();
		foreach (pat_bytes[i]) line_buf.push_back(pat_bytes[i]);
		send_line();

		run_phase(16, 82, 1);
		run_phase(82, 16, 1);
		run_phase(0, 0, 1);

		drain();
		$display("run covered %0d characters in %0d lines under %0d pattern settings",
			chars_sent, sb.lines, settings_used);
		$display("%0d lines predicted to match, %0d over the length limit",
			sb.matched, sb.long_lines);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/wlm_pkg.sv
hw/rtl/wlm_cfg_regs.sv
hw/rtl/wlm_seg_match.sv
hw/rtl/wildcard_line_matcher.sv
dv/tb_wildcard_line_matcher.sv
